>>> rtl/core/lrus_pkg.sv
package lrus_pkg;

  // Width of the frame-count configuration register.
  localparam int unsigned FRAMES_W = 5;
  // Reset value of the frame-count register.
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;
  // Width of the page field on the ports.
  localparam int unsigned PORT_PAGE_W = 16;
  // Width of the running fault count.
  localparam int unsigned FAULT_W = 32;
  // Output packing: tdata holds evicted_page then fault_total.
  localparam int unsigned OUT_DATA_W = 48;
  // Input packing: tdata holds page_number.
  localparam int unsigned IN_DATA_W = 16;
  // tuser bit positions on the result channel.
  localparam int unsigned UBIT_FAULT = 0;
  localparam int unsigned UBIT_EVICT = 1;

  // Per-cell control, driven by the stack controller for each item.
  typedef struct packed {
    logic upd;         // an item is accepted this cycle
    logic hit;         // the page was found somewhere in the stack
    logic occ;         // this cell holds a resident page
    logic bottom;      // this cell holds the least recently used page
    logic miss_shift;  // on a miss this cell takes its upper neighbor's page
  } lrus_ctl_t;

endpackage

>>> rtl/core/lrus_cell.sv
module lrus_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  lrus_pkg::lrus_ctl_t   ctl,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [PAGE_BITS-1:0]  up_entry,
  input  logic                  match_below_in,
  input  logic [PAGE_BITS-1:0]  evict_below_in,
  output logic [PAGE_BITS-1:0]  entry,
  output logic                  match_below_out,
  output logic [PAGE_BITS-1:0]  evict_out
);
  import lrus_pkg::*;

  logic [PAGE_BITS-1:0] entry_r;
  logic                 match;
  logic                 shift;

  // Compare the referenced page against this resident entry.
  assign match = ctl.occ && (entry_r == page);

  // A match here or further down means this cell lies at or above the hit.
  assign match_below_out = match | match_below_in;

  // The bottom cell offers its page for eviction; the others pass it upward.
  assign evict_out = (ctl.bottom ? entry_r : '0) | evict_below_in;

  // On a hit the cells from the top to the hit position move down one place;
  // on a miss the cells from the top to the insertion point do.
  assign shift = ctl.hit ? match_below_out : ctl.miss_shift;

  always_ff @(posedge clk) begin
    if (ctl.upd && shift) begin
      entry_r <= up_entry;
    end
  end

  assign entry = entry_r;

endmodule

>>> rtl/core/lru_stack_page_replacement_top.sv
// LRU stack page replacement.
// The in_ channel carries one page reference per item; in_tlast marks the
// last reference of a string. Each accepted item yields exactly one result
// item on the out_ channel: page_fault and evict_valid in out_tuser, the
// evicted page and the running fault count in out_tdata.
// The stack is a row of cells, one per frame, the most recent page at the
// top. All cells compare in parallel and shift toward the bottom in the same
// cycle, so a result sits in the output register in the cycle after its item
// is accepted; one item per cycle is sustained while out_tready stays high.
// The output register frees the input side: a new item is taken whenever the
// register is empty or being emptied in the same cycle. While out_tready is
// low with a result pending, in_tready drops and the stack holds.
// The cfg_ port writes the frame count (1 to MAX_FRAMES; zero acts as one,
// larger values act as MAX_FRAMES); it is always ready. The user writes it
// only while no item is in flight; the block does not enforce this.
// Reset empties the stack, clears the fault count, sets four frames and
// drops out_tvalid. After the item flagged by in_tlast the stack and the
// count clear again.
module lru_stack_page_replacement_top #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel. tdata: page_number[15:0].
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lrus_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  // Result channel. tdata: evicted_page[15:0], fault_total[47:16].
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lrus_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: page_fault[0], evict_valid[1].
  output logic [1:0]                         out_tuser,
  // Configuration write: frames_in_use.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrus_pkg::FRAMES_W-1:0]      cfg_data
);
  import lrus_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LW = (CW > FRAMES_W) ? CW : FRAMES_W;

  logic [FRAMES_W-1:0]  frames_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;
  logic                 out_valid_r;
  logic                 out_fault_r, out_evict_r;
  logic [PORT_PAGE_W-1:0] out_evpage_r;
  logic [FAULT_W-1:0]   out_total_r;

  logic                 accept;
  logic [PAGE_BITS-1:0] page;
  logic [LW-1:0]        frames_ext, limit;
  logic                 full, hit;
  logic [CW-1:0]        pos_miss;

  lrus_ctl_t            ctl [MAX_FRAMES];
  logic [PAGE_BITS-1:0] entry [MAX_FRAMES];
  logic                 match_chain [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] evict_chain [MAX_FRAMES+1];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign page      = PAGE_BITS'(in_tdata);

  // Effective frame limit, clamped to one through MAX_FRAMES.
  assign frames_ext = LW'(frames_r);
  always_comb begin
    if (frames_ext == '0) begin
      limit = LW'(1);
    end else if (frames_ext > LW'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = frames_ext;
    end
  end

  assign full     = LW'(count_r) >= limit;
  assign pos_miss = full ? (count_r - CW'(1)) : count_r;
  assign hit      = match_chain[0];

  // Ends of the cell chain.
  assign match_chain[MAX_FRAMES] = 1'b0;
  assign evict_chain[MAX_FRAMES] = '0;

  // The row of stack cells.
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    always_comb begin
      ctl[i].upd        = accept;
      ctl[i].hit        = hit;
      ctl[i].occ        = CW'(i) < count_r;
      ctl[i].bottom     = (CW'(i) + CW'(1)) == count_r;
      ctl[i].miss_shift = CW'(i) <= pos_miss;
    end

    if (i == 0) begin : g_top
      lrus_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
        .clk             (clk),
        .ctl             (ctl[i]),
        .page            (page),
        .up_entry        (page),
        .match_below_in  (match_chain[i+1]),
        .evict_below_in  (evict_chain[i+1]),
        .entry           (entry[i]),
        .match_below_out (match_chain[i]),
        .evict_out       (evict_chain[i])
      );
    end else begin : g_rest
      lrus_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
        .clk             (clk),
        .ctl             (ctl[i]),
        .page            (page),
        .up_entry        (entry[i-1]),
        .match_below_in  (match_chain[i+1]),
        .evict_below_in  (evict_chain[i+1]),
        .entry           (entry[i]),
        .match_below_out (match_chain[i]),
        .evict_out       (evict_chain[i])
      );
    end
  end

  // Resident count and saturating fault count for the next item.
  always_comb begin
    count_nxt = count_r;
    fault_nxt = fault_r;
    if (!hit) begin
      if (fault_r != '1) begin
        fault_nxt = fault_r + FAULT_W'(1);
      end
      if (!full) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  // Control state: configuration, counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r    <= FRAMES_RESET;
      count_r     <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_r <= cfg_data;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
        if (in_tlast) begin
          count_r <= '0;
          fault_r <= '0;
        end else begin
          count_r <= count_nxt;
          fault_r <= fault_nxt;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_fault_r  <= !hit;
      out_evict_r  <= !hit && full;
      out_evpage_r <= (!hit && full) ? PORT_PAGE_W'(evict_chain[0]) : '0;
      out_total_r  <= fault_nxt;
    end
  end

  assign out_tvalid            = out_valid_r;
  assign out_tdata             = {out_total_r, out_evpage_r};
  assign out_tuser[UBIT_FAULT] = out_fault_r;
  assign out_tuser[UBIT_EVICT] = out_evict_r;

  // The stack never holds more pages than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= LW'(MAX_FRAMES))
    else $error("resident count exceeds stack depth");

  // An accepted item always leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // An eviction only happens on a fault.
  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evict_r) |-> out_fault_r)
    else $error("eviction reported on a hit");

  // A hit that does not end a string leaves the resident count unchanged.
  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hit && !in_tlast) |=> (count_r == $past(count_r)))
    else $error("resident count changed on a hit");

endmodule

>>> verif/lru_stack_page_replacement_top_tb.sv
`timescale 1ns / 1ps

module lru_stack_page_replacement_top_tb;
  import lrus_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned NUM_DIRECTED = 21;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned REFS_PER_PHASE = 45;
  localparam int unsigned POOL_MAX = 20;
  localparam int unsigned SETTLE_CYCLES = 10;

  // Outcome of one page reference, as carried by the result channel.
  typedef struct packed {
    logic                 fault;
    logic                 evict;
    logic [PORT_PAGE_W-1:0] evicted;
    logic [FAULT_W-1:0]   total;
  } ref_outcome_t;

  // One row of the directed sequence. A row may first change the frame count.
  typedef struct packed {
    logic                 do_cfg;
    logic [FRAMES_W-1:0]  cfg_val;
    logic [PORT_PAGE_W-1:0] page;
    logic                 last;
    logic                 typed;
    ref_outcome_t         outcome;
  } directed_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [FRAMES_W-1:0]    cfg_data;

  // Predictor state.
  logic [PORT_PAGE_W-1:0] stack_pages [STACK_DEPTH];
  int unsigned            resident_pages;
  logic [FAULT_W-1:0]     faults_so_far;
  logic [FRAMES_W-1:0]    frames_setting;

  ref_outcome_t           pending_results [$];
  ref_outcome_t           observed;
  ref_outcome_t           predicted;
  int unsigned            check_errors;

  // Typed expectation that travels with the item on offer.
  logic                   row_typed;
  ref_outcome_t           row_expected;

  int unsigned            send_idle_pct;
  int unsigned            recv_idle_pct;
  int unsigned            hold_left;

  // Reference-string generator state.
  int unsigned            refs_left;
  int unsigned            pool_n;
  logic [PORT_PAGE_W-1:0] page_pool [POOL_MAX];

  // Directed sequence: the frame count starts at its reset value of four.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}},
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd2}},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd2}},
    '{1'b0, 5'd0,  16'h1234, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd3}},
    '{1'b0, 5'd0,  16'hABCD, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd4}},
    '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b1, '{1'b1, 1'b1, 16'hFFFF, 32'd5}},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'hAAAA, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'hABCD, 1'b1, 1'b0, '0},
    '{1'b0, 5'd0,  16'hABCD, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}},
    '{1'b0, 5'd0,  16'hABCD, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd1}},
    // A frame count of zero acts as one frame.
    '{1'b1, 5'd0,  16'h0001, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}},
    '{1'b0, 5'd0,  16'h0002, 1'b0, 1'b1, '{1'b1, 1'b1, 16'h0001, 32'd2}},
    '{1'b0, 5'd0,  16'h0002, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd2}},
    '{1'b0, 5'd0,  16'h0003, 1'b1, 1'b1, '{1'b1, 1'b1, 16'h0002, 32'd3}},
    // The largest setting saturates to the full stack depth.
    '{1'b1, 5'd31, 16'h8000, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0},
    // Frame count lowered below the resident count in the middle of a string.
    '{1'b1, 5'd1,  16'h4000, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'h2000, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'h7FFF, 1'b1, 1'b0, '0}
  };

  // Frame count used in each random phase.
  logic [FRAMES_W-1:0] phase_frames [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd5
  };

  lru_stack_page_replacement_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the outcome of one reference and advances the LRU stack.
  function automatic ref_outcome_t predict_reference(logic [PORT_PAGE_W-1:0] page,
                                                     logic last);
    ref_outcome_t res;
    int unsigned limit;
    int unsigned pos;
    bit found;
    res = '0;
    found = 1'b0;
    pos = 0;
    limit = 32'(frames_setting);
    if (limit < 1) limit = 1;
    if (limit > STACK_DEPTH) limit = STACK_DEPTH;
    for (int unsigned i = 0; i < resident_pages; i++) begin
      if (!found && stack_pages[i] == page) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (!found) begin
      res.fault = 1'b1;
      if (faults_so_far != '1) faults_so_far = faults_so_far + 1'b1;
      if (resident_pages >= limit) begin
        // Full, or over a lowered limit: only the bottom page leaves.
        res.evict = 1'b1;
        res.evicted = stack_pages[resident_pages-1];
        pos = resident_pages - 1;
      end else begin
        pos = resident_pages;
        resident_pages++;
      end
    end
    for (int unsigned i = pos; i > 0; i--) stack_pages[i] = stack_pages[i-1];
    stack_pages[0] = page;
    res.total = faults_so_far;
    if (last) begin
      resident_pages = 0;
      faults_so_far = '0;
    end
    return res;
  endfunction

  // Compares one observed result with its expectation, field by field.
  task automatic check_outcome(input ref_outcome_t got, input ref_outcome_t want);
    if (got.fault !== want.fault || got.evict !== want.evict ||
        got.evicted !== want.evicted || got.total !== want.total) begin
      check_errors++;
      if (check_errors <= 10)
        $display("%0t: result mismatch: fault %b/%b evict %b/%b page %h/%h total %0d/%0d",
                 $realtime, want.fault, got.fault, want.evict, got.evict,
                 want.evicted, got.evicted, want.total, got.total);
    end
  endtask

  // Offers one reference, with random idle cycles ahead of it.
  task automatic offer_ref(input logic [PORT_PAGE_W-1:0] page, input logic last,
                           input logic typed, input ref_outcome_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= page;
    in_tlast     <= last;
    row_typed    <= typed;
    row_expected <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Writes the frame count once every outstanding result has come back.
  task automatic set_frames(input logic [FRAMES_W-1:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Next reference of a random string. Pages mostly come from a small pool so
  // that hits and evictions both happen; a few are fully random, and now and
  // then a string is cut short.
  task automatic next_random_ref(output logic [PORT_PAGE_W-1:0] page, output logic last);
    if (refs_left == 0) begin
      refs_left = $urandom_range(40, 1);
      pool_n = $urandom_range(POOL_MAX, 1);
      for (int unsigned i = 0; i < POOL_MAX; i++) page_pool[i] = PORT_PAGE_W'($urandom);
    end
    if ($urandom_range(9) == 0) page = PORT_PAGE_W'($urandom);
    else page = page_pool[$urandom_range(pool_n - 1)];
    last = (refs_left == 1) || ($urandom_range(49) == 0);
    if (last) refs_left = 0;
    else refs_left--;
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: checks each result, then predicts from each accepted item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        observed.fault   = out_tuser[UBIT_FAULT];
        observed.evict   = out_tuser[UBIT_EVICT];
        observed.evicted = out_tdata[PORT_PAGE_W-1:0];
        observed.total   = out_tdata[PORT_PAGE_W +: FAULT_W];
        if (pending_results.size() == 0) begin
          check_errors++;
          if (check_errors <= 10)
            $display("%0t: result with no item outstanding: tuser %b tdata %h",
                     $realtime, out_tuser, out_tdata);
        end else begin
          check_outcome(observed, pending_results.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        predicted = predict_reference(in_tdata, in_tlast);
        pending_results.push_back(row_typed ? row_expected : predicted);
      end
      if (cfg_valid && cfg_ready) frames_setting = cfg_data;
    end
  end

  // Main sequence.
  initial begin
    logic [PORT_PAGE_W-1:0] page;
    logic last;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_expected = '0;
    send_idle_pct = 7;
    recv_idle_pct = 80;
    hold_left = 0;
    refs_left = 0;
    pool_n = 1;
    check_errors = 0;
    resident_pages = 0;
    faults_so_far = '0;
    frames_setting = FRAMES_RESET;
    for (int unsigned i = 0; i < STACK_DEPTH; i++) stack_pages[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].do_cfg) set_frames(directed_rows[r].cfg_val);
      offer_ref(directed_rows[r].page, directed_rows[r].last,
                directed_rows[r].typed, directed_rows[r].outcome);
    end

    // Random phases: strings may run across a change of the frame count.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_frames(phase_frames[p]);
      // With the sender offering every cycle, a long stall backs up the input.
      if (p == 6) hold_left = 60;
      for (int unsigned n = 0; n < REFS_PER_PHASE; n++) begin
        next_random_ref(page, last);
        offer_ref(page, last, 1'b0, '0);
      end
    end

    // Drain and let any stray result show up.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (check_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lrus_pkg.sv
rtl/core/lrus_cell.sv
rtl/core/lru_stack_page_replacement_top.sv
verif/lru_stack_page_replacement_top_tb.sv
